/* design/ulff_pkg.sv */
package ulff_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned CR_W         = 17;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_DONOR    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VANLEER  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUPERBEE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MINMOD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OSPRE    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ALBADA   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_MC       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMITER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COURANT      = 2'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_VANLEER;
  localparam logic [CR_W-1:0]   CR_RESET   = 17'd32768;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } clip_t;

  // saturate a wide signed value to 32 bits
  function automatic clip_t clip32(input logic signed [71:0] x);
    clip_t res;
    res.sat = 1'b0;
    res.val = x[31:0];
    if (x > 72'sd2147483647) begin
      res.sat = 1'b1;
      res.val = 32'sh7FFF_FFFF;
    end else if (x < -72'sd2147483648) begin
      res.sat = 1'b1;
      res.val = 32'sh8000_0000;
    end
    return res;
  endfunction

endpackage

/* design/ulff_div.sv */
module ulff_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          vld_q  [QW+1];
  logic [NW-1:0] rem_q  [QW+1];
  logic [DW-1:0] dvs_q  [QW+1];
  logic [QW-1:0] quot_q [QW+1];
  logic          ovf_q  [QW+1];
  logic [SW-1:0] side_q [QW+1];

  // quotient would not fit in QW bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= dividend_i;
      dvs_q[0]  <= divisor_i;
      quot_q[0] <= '0;
      ovf_q[0]  <= CW'(dividend_i) >= (CW'(divisor_i) << QW);
      side_q[0] <= side_i;
    end
  end

  // one restoring step per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int unsigned B = QW - 1 - k;
    logic [CW-1:0] shifted;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quot_d;

    always_comb begin
      shifted = CW'(dvs_q[k]) << B;
      ge      = CW'(rem_q[k]) >= shifted;
      rem_d   = ge ? NW'(CW'(rem_q[k]) - shifted) : rem_q[k];
      quot_d  = quot_q[k];
      quot_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        dvs_q[k+1]  <= dvs_q[k];
        quot_q[k+1] <= quot_d;
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = quot_q[QW];
  assign ovf_o   = ovf_q[QW];
  assign side_o  = side_q[QW];

endmodule

/* design/ulff_limiter.sv */
module ulff_limiter #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SW = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [ulff_pkg::MODE_W-1:0]     mode_i,
  input  logic                            valid_i,
  input  logic [31:0]                     quot_i,
  input  logic                            ovf_i,
  input  logic                            neg_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            valid_o,
  output logic signed [FRAC_BITS+2:0]     phi_o,
  output logic                            rsat_o,
  output logic [SW-1:0]                   side_o
);
  import ulff_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned PW  = F + 3;
  localparam int unsigned NW2 = 33 + F;
  localparam int unsigned DV2 = 64 - F;
  localparam int unsigned QW2 = F + 2;
  localparam int unsigned SW2 = SW + PW + 2;
  localparam longint ONE = longint'(1) << F;

  function automatic logic signed [33:0] smin(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [33:0] smax(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    return (a > b) ? a : b;
  endfunction

  // stage 1: signed, clipped ratio r
  logic               vld1_q, rsat1_q;
  logic signed [31:0] r1_q;
  logic [SW-1:0]      side1_q;
  logic signed [31:0] r1_d;
  logic               rsat1_d;

  always_comb begin
    if (neg_i) begin
      rsat1_d = ovf_i || (quot_i > 32'h8000_0000);
      r1_d    = rsat1_d ? 32'sh8000_0000 : $signed(32'(-quot_i));
    end else begin
      rsat1_d = ovf_i || quot_i[31];
      r1_d    = rsat1_d ? 32'sh7FFF_FFFF : $signed(quot_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q    <= r1_d;
      rsat1_q <= rsat1_d;
      side1_q <= side_i;
    end
  end

  // stage 2: square term for ospre / van Albada, min/max limiters directly
  logic               vld2_q, rsat2_q;
  logic signed [31:0] r2_q;
  logic signed [64:0] prod2_q;
  logic signed [PW-1:0] dphi2_q;
  logic [SW-1:0]      side2_q;
  logic signed [32:0] mb;
  logic signed [64:0] prod2_d;
  logic signed [33:0] r34, two_r, lim_a, lim_b;
  logic signed [PW-1:0] dphi2_d;

  always_comb begin
    mb      = (mode_i == MODE_OSPRE) ? 33'(r1_q) + 33'(ONE) : 33'(r1_q);
    prod2_d = r1_q * mb;
    r34     = 34'(r1_q);
    two_r   = r34 <<< 1;
    lim_a   = '0;
    lim_b   = '0;
    dphi2_d = '0;
    unique case (mode_i)
      MODE_SUPERBEE: begin
        lim_a   = smax(34'sd0, smin(two_r, 34'(ONE)));
        lim_b   = smin(r34, 34'(2 * ONE));
        dphi2_d = PW'(smax(lim_a, lim_b));
      end
      MODE_MINMOD: begin
        dphi2_d = PW'(smax(34'sd0, smin(34'(ONE), r34)));
      end
      MODE_MC: begin
        lim_a   = (r34 + 34'(ONE)) >>> 1;
        lim_b   = smin(lim_a, smin(two_r, 34'(2 * ONE)));
        dphi2_d = PW'(smax(34'sd0, lim_b));
      end
      default: dphi2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q    <= r1_q;
      prod2_q <= prod2_d;
      dphi2_q <= dphi2_d;
      rsat2_q <= rsat1_q;
      side2_q <= side1_q;
    end
  end

  // division operands for the rational limiters
  logic signed [64:0] q65;
  logic signed [33:0] num;
  logic [33:0]        num_mag;
  logic [NW2-1:0]     dvd;
  logic [DV2-1:0]     dvs;
  logic               lneg;

  always_comb begin
    q65     = prod2_q >>> F;
    num     = 34'(r2_q) - 34'(ONE);
    num_mag = num[33] ? 34'(-num) : 34'(num);
    dvd     = '0;
    dvs     = DV2'(1);
    lneg    = 1'b0;
    unique case (mode_i)
      MODE_VANLEER: begin
        if (r2_q > 0) begin
          dvd = NW2'(r2_q) << (F + 1);
          dvs = DV2'(r2_q) + DV2'(ONE);
        end
      end
      MODE_OSPRE: begin
        dvd = NW2'(3) << (2 * F - 1);
        dvs = DV2'(q65 + ONE);
      end
      MODE_ALBADA: begin
        dvd  = NW2'(num_mag) << F;
        dvs  = DV2'(q65 + ONE);
        lneg = num[33];
      end
      default: begin
        dvd = '0;
        dvs = DV2'(1);
      end
    endcase
  end

  logic           dv_vld, dv_ovf;
  logic [QW2-1:0] dv_quot;
  logic [SW2-1:0] dv_side;

  ulff_div #(
    .NW(NW2),
    .DW(DV2),
    .QW(QW2),
    .SW(SW2)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en_i),
    .valid_i    (vld2_q),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .side_i     ({lneg, dphi2_q, rsat2_q, side2_q}),
    .valid_o    (dv_vld),
    .quot_o     (dv_quot),
    .ovf_o      (dv_ovf),
    .side_o     (dv_side)
  );

  // final phi
  logic                 vld4_q, rsat4_q;
  logic signed [PW-1:0] phi4_q;
  logic [SW-1:0]        side4_q;
  logic signed [PW-1:0] phi4_d, quot_s, dphi_o;
  logic                 lneg_o;

  always_comb begin
    lneg_o = dv_side[SW2-1];
    dphi_o = $signed(dv_side[SW+PW:SW+1]);
    quot_s = $signed(PW'(dv_quot));
    unique case (mode_i)
      MODE_VANLEER: phi4_d = quot_s;
      MODE_OSPRE:   phi4_d = PW'(3 * (ONE >>> 1)) - quot_s;
      MODE_ALBADA:  phi4_d = lneg_o ? PW'(ONE) - quot_s : PW'(ONE) + quot_s;
      default:      phi4_d = dphi_o;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= dv_vld;
    end
  end

  // quotient always fits here, so the overflow flag only masks nothing
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phi4_q  <= dv_ovf ? phi4_d : phi4_d;
      rsat4_q <= dv_side[SW];
      side4_q <= dv_side[SW-1:0];
    end
  end

  assign valid_o = vld4_q;
  assign phi_o   = phi4_q;
  assign rsat_o  = rsat4_q;
  assign side_o  = side4_q;

endmodule

/* design/upwind_limited_face_flux_unit.sv */
// Flux-limited upwind face flux, one face per word.
// Throughput: one word per cycle while the skid word is empty; the delay is set by
// the two bit-per-stage restoring dividers (ratio r, then the limiter quotient)
// plus five multiply/clip stages.
// Reset: asynchronous, active low; empties the pipeline and loads limiter_mode = 1
// and courant_ratio = 0.5.
module upwind_limited_face_flux_unit #(
  parameter int unsigned FRAC_BITS = ulff_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ulff_pkg::DATA_W-1:0]   face_velocity_i,
  input  logic signed [ulff_pkg::DATA_W-1:0]   value_back_two_i,
  input  logic signed [ulff_pkg::DATA_W-1:0]   value_back_one_i,
  input  logic signed [ulff_pkg::DATA_W-1:0]   value_here_i,
  input  logic signed [ulff_pkg::DATA_W-1:0]   value_ahead_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ulff_pkg::DATA_W-1:0]   face_flux_o,
  output logic                                 saturated_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ulff_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ulff_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ulff_pkg::*;

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned CW  = 50 - F;
  localparam int unsigned WW  = CW + 1;
  localparam int unsigned PW  = F + 3;
  localparam int unsigned NW1 = 32 + F;
  localparam longint ONE = longint'(1) << F;

  typedef struct packed {
    logic signed [31:0]   v;
    logic signed [31:0]   up;
    logic signed [32:0]   dh;
    logic                 pos;
    logic signed [CW-1:0] c;
    logic signed [31:0]   dflux;
    logic                 dsat;
  } side_t;

  localparam int unsigned SW = $bits(side_t);

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [CR_W-1:0]   cr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      cr_q   <= CR_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_LIMITER_MODE) begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end else if (cfg_index_i == CFG_COURANT) begin
        cr_q <= cfg_data_i[CR_W-1:0];
      end
    end
  end

  // whole pipeline holds while the skid word is occupied
  logic skid_vld_q;
  logic en;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // stage 0: input capture
  logic               vld0_q;
  logic signed [31:0] v0_q, b2_0_q, b1_0_q, h0_q, a0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v0_q   <= face_velocity_i;
      b2_0_q <= value_back_two_i;
      b1_0_q <= value_back_one_i;
      h0_q   <= value_here_i;
      a0_q   <= value_ahead_i;
    end
  end

  // stage 1: upwind select, differences, products
  logic               pos1_d;
  logic signed [31:0] up1_d;
  logic signed [32:0] dh1_d, du1_d, den1_d;
  logic signed [63:0] dprod1_d;
  logic signed [49:0] cprod1_d;

  always_comb begin
    pos1_d   = v0_q > 0;
    up1_d    = pos1_d ? b1_0_q : h0_q;
    dh1_d    = 33'(h0_q) - 33'(b1_0_q);
    du1_d    = pos1_d ? 33'(b1_0_q) - 33'(b2_0_q) : 33'(a0_q) - 33'(h0_q);
    den1_d   = (dh1_d != 0) ? dh1_d : 33'sd1;
    dprod1_d = v0_q * up1_d;
    cprod1_d = v0_q * $signed({1'b0, cr_q});
  end

  logic               vld1_q, pos1_q, rneg1_q;
  logic signed [31:0] v1_q, up1_q;
  logic signed [32:0] dh1_q;
  logic [31:0]        dumag1_q, denmag1_q;
  logic signed [63:0] dprod1_q;
  logic signed [49:0] cprod1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q    <= pos1_d;
      v1_q      <= v0_q;
      up1_q     <= up1_d;
      dh1_q     <= dh1_d;
      dumag1_q  <= du1_d[32] ? 32'(-du1_d) : 32'(du1_d);
      denmag1_q <= den1_d[32] ? 32'(-den1_d) : 32'(den1_d);
      rneg1_q   <= du1_d[32] ^ den1_d[32];
      dprod1_q  <= dprod1_d;
      cprod1_q  <= cprod1_d;
    end
  end

  side_t side1;
  clip_t dclip;

  always_comb begin
    dclip       = clip32(72'(dprod1_q >>> F));
    side1.v     = v1_q;
    side1.up    = up1_q;
    side1.dh    = dh1_q;
    side1.pos   = pos1_q;
    side1.c     = CW'(cprod1_q >>> F);
    side1.dflux = dclip.val;
    side1.dsat  = dclip.sat;
  end

  // ratio r = du * ONE / den
  logic          r_vld, r_ovf;
  logic [31:0]   r_quot;
  logic [SW:0]   r_side;

  ulff_div #(
    .NW(NW1),
    .DW(32),
    .QW(32),
    .SW(SW + 1)
  ) u_rdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (vld1_q),
    .dividend_i (NW1'(dumag1_q) << F),
    .divisor_i  (denmag1_q),
    .side_i     ({rneg1_q, side1}),
    .valid_o    (r_vld),
    .quot_o     (r_quot),
    .ovf_o      (r_ovf),
    .side_o     (r_side)
  );

  logic                 l_vld, l_rsat;
  logic signed [PW-1:0] l_phi;
  logic [SW-1:0]        l_side;

  ulff_limiter #(
    .FRAC_BITS(FRAC_BITS),
    .SW(SW)
  ) u_limiter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .mode_i  (mode_q),
    .valid_i (r_vld),
    .quot_i  (r_quot),
    .ovf_i   (r_ovf),
    .neg_i   (r_side[SW]),
    .side_i  (r_side[SW-1:0]),
    .valid_o (l_vld),
    .phi_o   (l_phi),
    .rsat_o  (l_rsat),
    .side_o  (l_side)
  );

  // B1: w * phi
  side_t                   sl;
  logic signed [WW-1:0]    w_d;
  logic signed [WW+PW-1:0] wp_d;

  always_comb begin
    sl   = side_t'(l_side);
    w_d  = sl.pos ? WW'(ONE) - WW'(sl.c) : WW'(ONE) + WW'(sl.c);
    wp_d = w_d * l_phi;
  end

  logic                    vb1_q, sat_b1_q;
  logic signed [WW+PW-1:0] wp_q;
  side_t                   s_b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
    end else if (en) begin
      vb1_q <= l_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wp_q     <= wp_d;
      sat_b1_q <= l_rsat;
      s_b1_q   <= sl;
    end
  end

  // B2: t = clip(w*phi >> F)
  clip_t tclip;
  assign tclip = clip32(72'(wp_q >>> F));

  logic               vb2_q, sat_b2_q;
  logic signed [31:0] t_q;
  side_t              s_b2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb2_q <= 1'b0;
    end else if (en) begin
      vb2_q <= vb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q      <= tclip.val;
      sat_b2_q <= sat_b1_q | tclip.sat;
      s_b2_q   <= s_b1_q;
    end
  end

  // B3: t * dh
  logic signed [64:0] tp_d;
  assign tp_d = t_q * s_b2_q.dh;

  logic               vb3_q, sat_b3_q;
  logic signed [64:0] tp_q;
  side_t              s_b3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb3_q <= 1'b0;
    end else if (en) begin
      vb3_q <= vb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tp_q     <= tp_d;
      sat_b3_q <= sat_b2_q;
      s_b3_q   <= s_b2_q;
    end
  end

  // B4: face value = up +/- half-slope correction
  logic signed [64:0] corr;
  logic signed [71:0] face_raw;
  clip_t              fclip;

  always_comb begin
    corr     = tp_q >>> (F + 1);
    face_raw = s_b3_q.pos ? 72'(s_b3_q.up) + 72'(corr) : 72'(s_b3_q.up) - 72'(corr);
    fclip    = clip32(face_raw);
  end

  logic               vb4_q, sat_b4_q;
  logic signed [31:0] face_q;
  side_t              s_b4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb4_q <= 1'b0;
    end else if (en) begin
      vb4_q <= vb3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      face_q   <= fclip.val;
      sat_b4_q <= sat_b3_q | fclip.sat;
      s_b4_q   <= s_b3_q;
    end
  end

  // B5: v * face
  logic signed [63:0] vp_d;
  assign vp_d = s_b4_q.v * face_q;

  logic               vb5_q, sat_b5_q;
  logic signed [63:0] vp_q;
  side_t              s_b5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb5_q <= 1'b0;
    end else if (en) begin
      vb5_q <= vb4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vp_q     <= vp_d;
      sat_b5_q <= sat_b4_q;
      s_b5_q   <= s_b4_q;
    end
  end

  // final select; donor cell (and the spare mode) ignores every limited-path flag
  clip_t              flclip;
  logic signed [31:0] fin_flux;
  logic               fin_sat;

  always_comb begin
    flclip = clip32(72'(vp_q >>> F));
    if (mode_q == MODE_DONOR || mode_q == MODE_SPARE) begin
      fin_flux = s_b5_q.dflux;
      fin_sat  = s_b5_q.dsat;
    end else begin
      fin_flux = flclip.val;
      fin_sat  = sat_b5_q | flclip.sat;
    end
  end

  // output register plus skid word
  logic               out_vld_q, out_vld_d;
  logic signed [31:0] out_flux_q, out_flux_d;
  logic               out_sat_q, out_sat_d;
  logic               skid_vld_d;
  logic signed [31:0] skid_flux_q, skid_flux_d;
  logic               skid_sat_q, skid_sat_d;
  logic               arrive;

  always_comb begin
    arrive      = en && vb5_q;
    out_vld_d   = out_vld_q;
    out_flux_d  = out_flux_q;
    out_sat_d   = out_sat_q;
    skid_vld_d  = skid_vld_q;
    skid_flux_d = skid_flux_q;
    skid_sat_d  = skid_sat_q;
    if (!out_vld_q || !out_stall_i) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_flux_d = skid_flux_q;
        out_sat_d  = skid_sat_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d  = arrive;
        out_flux_d = fin_flux;
        out_sat_d  = fin_sat;
      end
    end else if (arrive) begin
      skid_vld_d  = 1'b1;
      skid_flux_d = fin_flux;
      skid_sat_d  = fin_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_flux_q  <= out_flux_d;
    out_sat_q   <= out_sat_d;
    skid_flux_q <= skid_flux_d;
    skid_sat_q  <= skid_sat_d;
  end

  assign out_valid_o = out_vld_q;
  assign face_flux_o = out_flux_q;
  assign saturated_o = out_sat_q;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ulff_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 47 + 20;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 10;
  localparam int WORDS_PER_PHASE = 153;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [31:0] vel;
    logic signed [31:0] back_two;
    logic signed [31:0] back_one;
    logic signed [31:0] here;
    logic signed [31:0] ahead;
  } face_word_t;

  typedef struct {
    logic signed [31:0] flux;
    logic               sat;
  } flux_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] face_velocity_i = '0;
  logic signed [31:0] value_back_two_i = '0;
  logic signed [31:0] value_back_one_i = '0;
  logic signed [31:0] value_here_i = '0;
  logic signed [31:0] value_ahead_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] face_flux_o;
  logic saturated_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  upwind_limited_face_flux_unit dut (.*);

  always #2 clk_i = ~clk_i;

  face_word_t pending_faces[$];
  flux_word_t expected_fluxes[$];
  logic [MODE_W-1:0] cur_mode = MODE_RESET;
  longint cur_courant = longint'(CR_RESET);
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int faces_sent = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic in_took = 1'b0;

  function automatic longint lo(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint hi(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint clip_word(longint x, inout logic sat);
    if (x > longint'(WORD_MAX)) begin
      sat = 1'b1;
      return longint'(WORD_MAX);
    end
    if (x < longint'(WORD_MIN)) begin
      sat = 1'b1;
      return longint'(WORD_MIN);
    end
    return x;
  endfunction

  function automatic longint limiter_phi(logic [MODE_W-1:0] mode, longint r);
    longint q;
    case (mode)
      MODE_VANLEER: begin
        if (r <= 0) return 0;
        return (2 * r * ONE) / (ONE + r);
      end
      MODE_SUPERBEE: return hi(hi(0, lo(2 * r, ONE)), lo(r, 2 * ONE));
      MODE_MINMOD: return hi(0, lo(ONE, r));
      MODE_OSPRE: begin
        q = (r * (r + ONE)) >>> FRAC_BITS_DEF;
        return (3 * ONE) / 2 - ((3 * ONE * ONE) / 2) / (q + ONE);
      end
      MODE_ALBADA: begin
        q = (r * r) >>> FRAC_BITS_DEF;
        return ONE + ((r - ONE) * ONE) / (q + ONE);
      end
      default: return hi(0, lo((r + ONE) >>> 1, lo(2 * r, 2 * ONE)));
    endcase
  endfunction

  function automatic flux_word_t predict_flux(face_word_t f);
    flux_word_t res;
    logic sat;
    longint v, b2, b1, h, a, up, dh, du, den, r, phi, c, w, t, corr, face;
    bit pos;
    sat = 1'b0;
    v = f.vel;
    b2 = f.back_two;
    b1 = f.back_one;
    h = f.here;
    a = f.ahead;
    pos = v > 0;
    up = pos ? b1 : h;
    if (cur_mode == MODE_DONOR || cur_mode == MODE_SPARE) begin
      res.flux = clip_word((v * up) >>> FRAC_BITS_DEF, sat);
    end else begin
      dh = h - b1;
      du = pos ? (b1 - b2) : (a - h);
      den = (dh != 0) ? dh : 1;
      r = clip_word((du * ONE) / den, sat);
      phi = limiter_phi(cur_mode, r);
      c = (v * cur_courant) >>> FRAC_BITS_DEF;
      w = pos ? (ONE - c) : (ONE + c);
      t = clip_word((w * phi) >>> FRAC_BITS_DEF, sat);
      corr = (t * dh) >>> (FRAC_BITS_DEF + 1);
      face = clip_word(pos ? (up + corr) : (up - corr), sat);
      res.flux = clip_word((v * face) >>> FRAC_BITS_DEF, sat);
    end
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    error_count++;
  endtask

  // input side: new word only once the previous one was taken
  always @(negedge clk_i) begin
    face_word_t f;
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pending_faces.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        f = pending_faces.pop_front();
        face_velocity_i <= f.vel;
        value_back_two_i <= f.back_two;
        value_back_one_i <= f.back_one;
        value_here_i <= f.here;
        value_ahead_i <= f.ahead;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side stall, with one long hold so the pipe backs up
  always @(negedge clk_i) begin
    if (!hold_done && faces_sent >= 1200) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    face_word_t f;
    flux_word_t want;
    in_took <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      f.vel = face_velocity_i;
      f.back_two = value_back_two_i;
      f.back_one = value_back_one_i;
      f.here = value_here_i;
      f.ahead = value_ahead_i;
      expected_fluxes.push_back(predict_flux(f));
      faces_sent++;
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_fluxes.size() == 0) begin
        // result word with nothing expected
        report_mismatch("pending result count", 0, 1);
      end else begin
        want = expected_fluxes.pop_front();
        if (face_flux_o !== want.flux)
          report_mismatch("face_flux", want.flux, face_flux_o);
        if (saturated_o !== want.sat)
          report_mismatch("saturated", want.sat, saturated_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_face(logic signed [31:0] v, logic signed [31:0] b2,
                          logic signed [31:0] b1, logic signed [31:0] h,
                          logic signed [31:0] a);
    face_word_t f;
    f.vel = v;
    f.back_two = b2;
    f.back_one = b1;
    f.here = h;
    f.ahead = a;
    pending_faces.push_back(f);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
      3: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
      4: return 0;
      5: return $signed($urandom_range(0, 2)) - 1;
      default: return $signed($urandom_range(0, 200 * ONE)) - 100 * ONE;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_step();
    return $signed($urandom_range(0, 4 * ONE)) - 2 * ONE;
  endfunction

  task automatic add_random_face();
    logic signed [31:0] base, b1, h;
    if ($urandom_range(0, 9) < 7) begin
      // smooth profile so the limiter ratio lands in a useful range
      base = $signed($urandom_range(0, 64 * ONE)) - 32 * ONE;
      b1 = base + rand_step();
      h = ($urandom_range(0, 9) == 0) ? b1 : b1 + rand_step();
      add_face(rand_value(), base, b1, h, h + rand_step());
    end else begin
      add_face(rand_value(), rand_value(), rand_value(), rand_value(), rand_value());
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_LIMITER_MODE) cur_mode = data[MODE_W-1:0];
    else if (idx == CFG_COURANT) cur_courant = longint'(data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_faces.size() > 0 || in_valid_i || expected_fluxes.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [MODE_W-1:0] modes[PHASES];
    logic [CFG_DATA_W-1:0] ratios[PHASES];
    modes = '{MODE_DONOR, MODE_VANLEER, MODE_SUPERBEE, MODE_MINMOD, MODE_OSPRE,
              MODE_ALBADA, MODE_MC, MODE_SPARE, MODE_MC, MODE_VANLEER};
    ratios = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd65536,
               17'd0, 17'd32768, 17'd65536, 17'd0, 17'd65536};
    ratios[3] = $urandom_range(0, 65536);
    ratios[6] = $urandom_range(0, 65536);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words under the reset settings
    add_face(0, 1, 2, 3, 4);
    add_face(0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    add_face(ONE, 0, ONE, 2 * ONE, 3 * ONE);
    add_face(-ONE, 0, ONE, 2 * ONE, 3 * ONE);
    add_face(ONE, 0, 5 * ONE, 5 * ONE, 0);
    add_face(-ONE, 3 * ONE, 5 * ONE, 5 * ONE, 0);
    add_face(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
    add_face(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    add_face(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    add_face(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    add_face(WORD_MAX, 0, ONE, 3 * ONE, 4 * ONE);
    add_face(1, 0, -ONE, ONE, 2 * ONE);
    add_face(-1, 2 * ONE, ONE, -ONE, 0);
    add_face(ONE, 4 * ONE, ONE, 2 * ONE, 0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 4) ? 24 : (p < 7) ? 63 : 0;
      recv_idle_pct = (p < 4) ? 63 : (p < 7) ? 24 : 0;
      write_reg(CFG_LIMITER_MODE, CFG_DATA_W'(modes[p]));
      write_reg(CFG_COURANT, ratios[p]);
      // an index past the register list must leave both registers alone
      if (p == 5) write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
      for (int i = 0; i < WORDS_PER_PHASE; i++) add_random_face();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
